@@ rtl/wpfd_pkg.sv @@
// wpfd_pkg: types and constants shared by the wire primitive field decoder
// holds transfer payload structs, field kind codes, status codes and the step bundle
// no dependencies
`default_nettype none

package wpfd_pkg;

    // field kind codes carried on mode
    localparam logic [3:0] KIND_INT8         = 4'd0;
    localparam logic [3:0] KIND_INT16        = 4'd1;
    localparam logic [3:0] KIND_INT32        = 4'd2;
    localparam logic [3:0] KIND_INT64        = 4'd3;
    localparam logic [3:0] KIND_UINT32       = 4'd4;
    localparam logic [3:0] KIND_VARINT       = 4'd5;
    localparam logic [3:0] KIND_UVARINT      = 4'd6;
    localparam logic [3:0] KIND_VARLONG      = 4'd7;
    localparam logic [3:0] KIND_UVARLONG     = 4'd8;
    localparam logic [3:0] KIND_COMPACT_LEN  = 4'd9;
    localparam logic [3:0] KIND_NULLABLE_LEN = 4'd10;
    localparam logic [3:0] KIND_BYTES_LEN    = 4'd11;
    localparam logic [3:0] KIND_TAGGED       = 4'd12;

    // result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_OVERLONG = 2'd1;
    localparam logic [1:0] STATUS_TAG_BAD  = 2'd2;

    // varint length limits in bytes
    localparam logic [3:0] VARINT_LIMIT  = 4'd5;
    localparam logic [3:0] VARLONG_LIMIT = 4'd10;

    localparam logic [7:0] CONT_BIT = 8'h80;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [3:0] mode;
    } wpfd_in_t;

    typedef struct packed {
        logic [63:0] field_value;
        logic        is_null;
        logic [1:0]  status;
    } wpfd_out_t;

    // per-byte decision from the accumulate stage
    typedef struct packed {
        logic        done;
        logic        overlong;
        logic [63:0] acc;
        logic [3:0]  taken;
        logic [3:0]  kind;
    } wpfd_step_t;

    function automatic logic [3:0] fixed_length(input logic [3:0] kind);
        logic [3:0] len;
        begin
            unique case (kind)
                KIND_INT16, KIND_NULLABLE_LEN:           len = 4'd2;
                KIND_INT32, KIND_UINT32, KIND_BYTES_LEN: len = 4'd4;
                KIND_INT64:                              len = 4'd8;
                default:                                 len = 4'd1;
            endcase
            return len;
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/wire_primitive_field_decoder_top.sv @@
// wire_primitive_field_decoder_top: byte-serial decoder for primitive wire fields
// instantiates wpfd_accum and wpfd_finish; uses wpfd_pkg
`default_nettype none

// One stream byte is taken per transfer on the item channel, and the block
// sustains one byte per clock while result_stall does not hold it. Each byte
// lands in an input register; when the stage advances, the accumulate and
// finish logic works on it against the field state (accumulator, byte count,
// kind, in-field flag) and, when the field completes, loads the result
// register, so a result passes through both registers. The only loop is the
// field state feeding back through the accumulate logic, one byte per cycle.
// While a result waits on result_stall the input register still takes a byte
// if it is empty; it holds once both registers are full. mode is sampled only
// on the first byte of a field. Varints longer than 5 bytes (varlong 10) give
// a status-overlong result and the decoder returns to idle. No memory, no clearing pass.
module wire_primitive_field_decoder_top (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       item_valid,
    output logic                      item_stall,
    input  wire wpfd_pkg::wpfd_in_t   item,
    output logic                      result_valid,
    input  wire                       result_stall,
    output wpfd_pkg::wpfd_out_t       result
);
    import wpfd_pkg::*;

    // input register
    logic       stage_valid_reg;
    logic       stage_valid_next;
    wpfd_in_t   stage_reg;

    // field state
    logic        in_field_reg;
    logic        in_field_next;
    logic [3:0]  kind_reg;
    logic [3:0]  kind_next;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic [3:0]  taken_reg;
    logic [3:0]  taken_next;

    // result register
    logic       result_valid_reg;
    logic       result_valid_next;
    wpfd_out_t  result_reg;
    wpfd_out_t  result_next;

    logic       advance;
    logic       item_take;
    wpfd_step_t step;
    wpfd_out_t  finished;

    wpfd_accum u_accum (
        .item      (stage_reg),
        .in_field  (in_field_reg),
        .kind_cur  (kind_reg),
        .acc_cur   (acc_reg),
        .taken_cur (taken_reg),
        .step      (step)
    );

    wpfd_finish u_finish (
        .kind   (step.kind),
        .acc    (step.acc),
        .result (finished)
    );

    // the stage moves on when the result slot is free or being drained
    assign advance    = !result_valid_reg || !result_stall;
    assign item_stall = stage_valid_reg && !advance;
    assign item_take  = item_valid && !item_stall;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (item_take)
        begin
            stage_valid_next = 1'b1;
        end
        else if (advance)
        begin
            stage_valid_next = 1'b0;
        end

        in_field_next     = in_field_reg;
        kind_next         = kind_reg;
        acc_next          = acc_reg;
        taken_next        = taken_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;

        if (advance)
        begin
            result_valid_next = stage_valid_reg && step.done;
            if (stage_valid_reg)
            begin
                if (step.done)
                begin
                    // field complete: back to idle
                    in_field_next = 1'b0;
                    kind_next     = 4'd0;
                    acc_next      = 64'd0;
                    taken_next    = 4'd0;
                end
                else
                begin
                    in_field_next = 1'b1;
                    kind_next     = step.kind;
                    acc_next      = step.acc;
                    taken_next    = step.taken;
                end
                if (step.overlong)
                begin
                    result_next.field_value = 64'd0;
                    result_next.is_null     = 1'b0;
                    result_next.status      = STATUS_OVERLONG;
                end
                else
                begin
                    result_next = finished;
                end
            end
        end
    end

    // control and field state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
            in_field_reg     <= 1'b0;
            kind_reg         <= 4'd0;
            acc_reg          <= 64'd0;
            taken_reg        <= 4'd0;
        end
        else
        begin
            stage_valid_reg  <= stage_valid_next;
            result_valid_reg <= result_valid_next;
            in_field_reg     <= in_field_next;
            kind_reg         <= kind_next;
            acc_reg          <= acc_next;
            taken_reg        <= taken_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            stage_reg <= item;
        end
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // an overlong varint always reports a zero, non-null value
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && (result_reg.status == STATUS_OVERLONG)
        |-> (result_reg.field_value == 64'd0) && !result_reg.is_null)
        else $error("overlong result carries data");

    // a null length header never carries a value
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.is_null |-> result_reg.field_value == 64'd0)
        else $error("null result with nonzero value");

    // a field in progress never counts past the varlong limit
    assert property (@(posedge clk) disable iff (!rst_n)
        in_field_reg |-> taken_reg < VARLONG_LIMIT)
        else $error("byte count ran past the longest field");

    // a bad tagged byte is a nonzero byte-wide value
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && (result_reg.status == STATUS_TAG_BAD)
        |-> (result_reg.field_value[63:8] == 56'd0) && (result_reg.field_value[7:0] != 8'd0))
        else $error("tagged status without a nonzero byte");

    // a result held under stall must not be replaced by a new field
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_stall |=> result_valid_reg && $stable(result_reg))
        else $error("stalled result was overwritten");

endmodule

`default_nettype wire

@@ rtl/wpfd_accum.sv @@
// wpfd_accum: folds one stream byte into the field accumulator
// decides whether the field completes or overruns; uses wpfd_pkg
`default_nettype none

module wpfd_accum (
    input  wire wpfd_pkg::wpfd_in_t   item,
    input  wire                       in_field,
    input  wire logic [3:0]           kind_cur,
    input  wire logic [63:0]          acc_cur,
    input  wire logic [3:0]           taken_cur,
    output wpfd_pkg::wpfd_step_t      step
);
    import wpfd_pkg::*;

    logic [3:0]  kind;
    logic [63:0] acc;
    logic [3:0]  taken;
    logic        is_var;
    logic [3:0]  limit;
    logic [3:0]  taken_eff;
    logic [6:0]  shamt_wide;
    logic [5:0]  shamt;
    logic [63:0] var_acc;
    logic [3:0]  var_taken;
    logic [3:0]  fix_taken;

    always_comb
    begin
        kind  = in_field ? kind_cur  : item.mode;
        acc   = in_field ? acc_cur   : 64'd0;
        taken = in_field ? taken_cur : 4'd0;

        is_var = (kind == KIND_VARINT) || (kind == KIND_UVARINT) ||
                 (kind == KIND_VARLONG) || (kind == KIND_UVARLONG) ||
                 (kind == KIND_COMPACT_LEN);
        limit  = ((kind == KIND_VARLONG) || (kind == KIND_UVARLONG)) ?
                 VARLONG_LIMIT : VARINT_LIMIT;

        taken_eff  = (taken >= limit) ? (limit - 4'd1) : taken;
        // seven bits per group
        shamt_wide = {taken_eff, 3'b000} - {3'b000, taken_eff};
        shamt      = shamt_wide[5:0];
        var_acc    = acc | ({57'd0, item.data_byte[6:0]} << shamt);
        var_taken  = taken_eff + 4'd1;

        fix_taken  = taken + 4'd1;

        if (is_var)
        begin
            step.acc      = var_acc;
            step.taken    = var_taken;
            step.overlong = ((item.data_byte & CONT_BIT) != 8'd0) && (var_taken >= limit);
            step.done     = ((item.data_byte & CONT_BIT) == 8'd0) || step.overlong;
        end
        else
        begin
            step.acc      = {acc[55:0], item.data_byte};
            step.taken    = fix_taken;
            step.overlong = 1'b0;
            step.done     = fix_taken >= fixed_length(kind);
        end
        step.kind = kind;
    end

endmodule

`default_nettype wire

@@ rtl/wpfd_finish.sv @@
// wpfd_finish: turns a completed accumulator into the result fields
// sign extension, zigzag, length null rules and tagged check; uses wpfd_pkg
`default_nettype none

module wpfd_finish (
    input  wire logic [3:0]       kind,
    input  wire logic [63:0]      acc,
    output wpfd_pkg::wpfd_out_t   result
);
    import wpfd_pkg::*;

    logic [31:0] n32;
    logic [31:0] zz32;
    logic [63:0] zz64;

    always_comb
    begin
        n32  = acc[31:0];
        zz32 = {1'b0, n32[31:1]} ^ {32{n32[0]}};
        zz64 = {1'b0, acc[63:1]} ^ {64{acc[0]}};

        result.field_value = {56'd0, acc[7:0]};
        result.is_null     = 1'b0;
        result.status      = STATUS_OK;

        unique case (kind)
            KIND_INT8:     result.field_value = {{56{acc[7]}}, acc[7:0]};
            KIND_INT16:    result.field_value = {{48{acc[15]}}, acc[15:0]};
            KIND_INT32:    result.field_value = {{32{acc[31]}}, acc[31:0]};
            KIND_INT64, KIND_UVARLONG:
                result.field_value = acc;
            KIND_UINT32, KIND_UVARINT:
                result.field_value = {32'd0, n32};
            KIND_VARINT:   result.field_value = {{32{zz32[31]}}, zz32};
            KIND_VARLONG:  result.field_value = zz64;
            KIND_COMPACT_LEN:
            begin
                if (n32 == 32'd0)
                begin
                    result.is_null     = 1'b1;
                    result.field_value = 64'd0;
                end
                else
                begin
                    result.field_value = {32'd0, n32 - 32'd1};
                end
            end
            KIND_NULLABLE_LEN:
            begin
                if (acc[15])
                begin
                    result.is_null     = 1'b1;
                    result.field_value = 64'd0;
                end
                else
                begin
                    result.field_value = {49'd0, acc[14:0]};
                end
            end
            KIND_BYTES_LEN:
            begin
                if (acc[31])
                begin
                    result.is_null     = 1'b1;
                    result.field_value = 64'd0;
                end
                else
                begin
                    result.field_value = {33'd0, acc[30:0]};
                end
            end
            KIND_TAGGED:
            begin
                result.field_value = {56'd0, acc[7:0]};
                result.status      = (acc[7:0] != 8'd0) ? STATUS_TAG_BAD : STATUS_OK;
            end
            default:
                result.field_value = {56'd0, acc[7:0]};
        endcase
    end

endmodule

`default_nettype wire
